### hw/rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// Particle pool package
// Shared widths, codes and the command and status records that join the
// pool controller to its datapath.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int SLOT_W       = 6;
  localparam int CNT_W        = 7;
  localparam int CAPACITY_DEF = 64;
  localparam int DT_W         = 20;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;

  // Source of a write into the particle memory.
  typedef enum logic [1:0] {
    WR_CREATE = 2'd0,
    WR_MOVE   = 2'd1,
    WR_UPDATE = 2'd2
  } wr_src_t;

  // One stored particle.
  typedef struct packed {
    logic [63:0]        app;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        life;
    logic [31:0]        spawn;
  } particle_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              cap_in;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    wr_src_t           wr_src;
    logic              mul_en;
    logic              add_en;
    logic              out_load;
    logic              out_part;
    logic [1:0]        out_status;
    logic [SLOT_W-1:0] out_slot;
    logic [CNT_W-1:0]  out_count;
    logic              out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic              expired;
    logic              out_free;
  } stat_t;

endpackage

### hw/rtl/ppu_dpath.sv
// ----------------------------------------------------------------------------
// Particle pool datapath
// Holds the particle memory, the captured request, the motion arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module ppu_dpath import ppu_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output stat_t        st,
  input  logic [351:0] s_tdata,
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,
  output logic         m_tuser,
  output logic         m_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  particle_t          mem [CAPACITY];
  particle_t          rdata;
  particle_t          wdata;
  logic [1:0]         op;
  logic [SLOT_W-1:0]  slot;
  particle_t          inp;
  logic [31:0]        now;
  logic [DT_W-1:0]    dt;
  logic signed [52:0] prod_x, prod_y, prod_z;
  logic signed [31:0] npos_x, npos_y, npos_z;
  logic [32:0]        end_time;

  // Capture the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op          <= s_tuser;
      slot        <= s_tdata[5:0];
      inp.app     <= s_tdata[69:6];
      inp.pos_x   <= s_tdata[101:70];
      inp.pos_y   <= s_tdata[133:102];
      inp.pos_z   <= s_tdata[165:134];
      inp.vel_x   <= s_tdata[197:166];
      inp.vel_y   <= s_tdata[229:198];
      inp.vel_z   <= s_tdata[261:230];
      inp.life    <= s_tdata[293:262];
      inp.spawn   <= s_tdata[325:294];
      now         <= s_tdata[325:294];
      dt          <= s_tdata[345:326];
    end
  end

  // Select what a memory write stores.
  always_comb begin
    case (cmd.wr_src)
      WR_CREATE: wdata = inp;
      WR_MOVE:   wdata = rdata;
      WR_UPDATE: begin
        wdata       = rdata;
        wdata.pos_x = npos_x;
        wdata.pos_y = npos_y;
        wdata.pos_z = npos_z;
      end
      default:   wdata = rdata;
    endcase
  end

  // Particle memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  // Velocity times frame step, one product per axis.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_x <= 53'(rdata.vel_x * $signed({1'b0, dt}));
      prod_y <= 53'(rdata.vel_y * $signed({1'b0, dt}));
      prod_z <= 53'(rdata.vel_z * $signed({1'b0, dt}));
    end
  end

  // Floor the product to Q16.16, add and saturate.
  function automatic logic signed [31:0] sat_add(logic signed [31:0] p,
                                                  logic signed [52:0] q);
    logic signed [37:0] s;
    s = 38'(p) + 38'($signed(q[52:16]));
    if (s > 38'sd2147483647) begin
      sat_add = 32'sh7fffffff;
    end else if (s < -38'sd2147483648) begin
      sat_add = 32'sh80000000;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      npos_x <= sat_add(rdata.pos_x, prod_x);
      npos_y <= sat_add(rdata.pos_y, prod_y);
      npos_z <= sat_add(rdata.pos_z, prod_z);
    end
  end

  // Expiry test on the particle just read; the sum keeps its carry.
  assign end_time = {1'b0, rdata.spawn} + {1'b0, rdata.life};

  always_comb begin
    st.op       = op;
    st.slot     = slot;
    st.expired  = (end_time <= {1'b0, now});
    st.out_free = !m_tvalid || m_tready;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata[1:0]     <= cmd.out_status;
      m_tdata[7:2]     <= cmd.out_slot;
      m_tdata[71:8]    <= cmd.out_part ? rdata.app : 64'd0;
      m_tdata[103:72]  <= cmd.out_part ? rdata.pos_x : 32'd0;
      m_tdata[135:104] <= cmd.out_part ? rdata.pos_y : 32'd0;
      m_tdata[167:136] <= cmd.out_part ? rdata.pos_z : 32'd0;
      m_tdata[174:168] <= cmd.out_count;
      m_tdata[175]     <= 1'b0;
      m_tuser          <= cmd.out_part;
      m_tlast          <= cmd.out_last;
    end
  end

endmodule

### hw/rtl/ppu_ctrl.sv
// ----------------------------------------------------------------------------
// Particle pool controller
// Sequences create, destroy and the update walk, and keeps the live count.
// ----------------------------------------------------------------------------
module ppu_ctrl import ppu_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECODE  = 10'b0000000010,
    S_DEST_WR = 10'b0000000100,
    S_RESP    = 10'b0000001000,
    S_UPD_RD  = 10'b0000010000,
    S_UPD_CHK = 10'b0000100000,
    S_MOVE_WR = 10'b0001000000,
    S_UPD_ADD = 10'b0010000000,
    S_UPD_WR  = 10'b0100000000,
    S_EMIT    = 10'b1000000000
  } state_t;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [1:0]        resp_status, resp_status_next;
  logic [SLOT_W-1:0] resp_slot, resp_slot_next;
  logic [CNT_W-1:0]  last_idx;

  assign s_tready = (state == S_IDLE);
  assign last_idx = count - CNT_W'(1);

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      idx         <= '0;
      resp_status <= ST_OK;
      resp_slot   <= '0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      idx         <= idx_next;
      resp_status <= resp_status_next;
      resp_slot   <= resp_slot_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    resp_status_next = resp_status;
    resp_slot_next   = resp_slot;
    cmd              = '0;
    cmd.wr_src       = WR_CREATE;
    cmd.out_count    = count;
    case (state)
      S_IDLE: begin
        cmd.cap_in = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        resp_status_next = ST_OK;
        resp_slot_next   = '0;
        state_next       = S_RESP;
        case (st.op)
          OP_CREATE: begin
            if (count >= CAP) begin
              resp_status_next = ST_FULL;
            end else begin
              cmd.wr_en      = 1'b1;
              cmd.wr_addr    = count[SLOT_W-1:0];
              cmd.wr_src     = WR_CREATE;
              resp_slot_next = count[SLOT_W-1:0];
              count_next     = count + CNT_W'(1);
            end
          end
          OP_DESTROY: begin
            resp_slot_next = st.slot;
            if ({1'b0, st.slot} >= count) begin
              resp_status_next = ST_BAD_SLOT;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = last_idx[SLOT_W-1:0];
              state_next  = S_DEST_WR;
            end
          end
          OP_UPDATE: begin
            idx_next   = '0;
            state_next = S_UPD_RD;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_DEST_WR: begin
        // Move the last particle into the destroyed slot.
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = resp_slot;
        cmd.wr_src  = WR_MOVE;
        count_next  = last_idx;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_status;
          cmd.out_slot   = resp_slot;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_UPD_RD: begin
        if (idx >= count) begin
          idx_next = '0;
          if (count == '0) begin
            resp_status_next = ST_OK;
            resp_slot_next   = '0;
            state_next       = S_RESP;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            state_next  = S_EMIT;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx[SLOT_W-1:0];
          state_next  = S_UPD_CHK;
        end
      end
      S_UPD_CHK: begin
        if (st.expired) begin
          // Swap-remove: the last particle takes this slot, then recheck.
          count_next = last_idx;
          if (idx == last_idx) begin
            state_next = S_UPD_RD;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = last_idx[SLOT_W-1:0];
            state_next  = S_MOVE_WR;
          end
        end else begin
          cmd.mul_en = 1'b1;
          state_next = S_UPD_ADD;
        end
      end
      S_MOVE_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = idx[SLOT_W-1:0];
        cmd.wr_src  = WR_MOVE;
        state_next  = S_UPD_RD;
      end
      S_UPD_ADD: begin
        cmd.add_en = 1'b1;
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = idx[SLOT_W-1:0];
        cmd.wr_src  = WR_UPDATE;
        idx_next    = idx + CNT_W'(1);
        state_next  = S_UPD_RD;
      end
      S_EMIT: begin
        // The read data holds the particle at idx.
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_part   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_slot   = idx[SLOT_W-1:0];
          cmd.out_last   = (idx == last_idx);
          if (idx == last_idx) begin
            state_next = S_IDLE;
          end else begin
            idx_next    = idx + CNT_W'(1);
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = 6'(idx + CNT_W'(1));
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The live count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP) else $error("live count above capacity");

  // Every memory write lands inside the pool.
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> ({1'b0, cmd.wr_addr} < CAP)) else $error("write beyond capacity");

  // A result is only loaded into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free) else $error("output register overwritten");

  // An accepted request is always decoded next.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DECODE)) else $error("request not decoded");

  // Emitted particles lie below the live count.
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_part) |-> ({1'b0, cmd.out_slot} < count))
    else $error("emitted slot not live");
`endif

endmodule

### hw/rtl/particle_pool_update.sv
// ----------------------------------------------------------------------------
// Particle pool update
// Compact pool of live particles with create, swap-remove destroy and an
// update walk that ages, moves and emits every surviving particle.
//
// Channel   Direction  Signals
// s_*       in         tvalid, tready, tdata, tuser  (one request)
// m_*       out        tvalid, tready, tdata, tuser, tlast (results)
//
// Create runs through decode and the result state, and destroy adds a move write;
// both may wait for the output register. Update reads, checks, multiplies, adds
// and writes each surviving slot, reads, checks and may move into each expired
// one, then emits one result per cycle while the output is not stalled.
// Reset clears the live count; the memory needs no clearing pass.
// A stalled output holds the controller in its result or emit state.
// ----------------------------------------------------------------------------
module particle_pool_update import ppu_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot, appearance, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_span,
  // time_now, delta_time, zero pad
  input  logic [351:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, out_slot, out_appearance, out_pos_x, out_pos_y, out_pos_z,
  // live_count, zero pad
  output logic [175:0] m_tdata,
  // has_particle
  output logic         m_tuser,
  // last
  output logic         m_tlast
);

  cmd_t  cmd;
  stat_t st;

  // Sequencer.
  ppu_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Memory, arithmetic and output register.
  ppu_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
